FILE: hw/rtl/tla_pkg.sv
// Shared types and character constants for the text line assembler.
`default_nettype none

package tla_pkg;

  // Width of the held space count
  localparam int SPACE_W = 6;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_VIS_LO = 8'h20;
  localparam logic [7:0] CH_VIS_HI = 8'h7E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // One classified command: a line end, or held spaces followed by a character
  typedef struct packed {
    logic               is_end;
    logic [7:0]         ch;
    logic [SPACE_W-1:0] spaces;
  } tla_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tla_front.sv
// Front end: accepts bytes, tracks line state and issues commands to the queue.
`default_nettype none

module tla_front #(
  parameter int SPACE_RUN_MAX = 63
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte_in,
  input  wire logic              q_full,
  output logic                   q_push,
  output tla_pkg::tla_cmd_t      q_cmd
);
  import tla_pkg::*;

  localparam logic [SPACE_W-1:0] RUN_MAX = SPACE_W'(SPACE_RUN_MAX);

  logic               line_started_r, line_started_nxt;
  logic [SPACE_W-1:0] pending_r, pending_nxt;
  logic               term_run_r, term_run_nxt;
  logic               accept;
  logic               is_term;
  logic               is_vis;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_term  = (in_byte_in == CH_CR) || (in_byte_in == CH_LF);
  assign is_vis   = (in_byte_in >= CH_VIS_LO) && (in_byte_in <= CH_VIS_HI);

  // Classify the byte and update the line state
  always_comb begin
    line_started_nxt = line_started_r;
    pending_nxt      = pending_r;
    term_run_nxt     = term_run_r;
    q_push           = 1'b0;
    q_cmd.is_end     = 1'b0;
    q_cmd.ch         = in_byte_in;
    q_cmd.spaces     = pending_r;
    if (accept) begin
      if (is_term) begin
        if (!term_run_r) begin
          q_push           = 1'b1;
          q_cmd.is_end     = 1'b1;
          q_cmd.ch         = 8'h00;
          q_cmd.spaces     = '0;
          line_started_nxt = 1'b0;
          pending_nxt      = '0;
          term_run_nxt     = 1'b1;
        end
      end else begin
        term_run_nxt = 1'b0;
        if (is_vis) begin
          if (in_byte_in == CH_SPACE) begin
            // Hold inner spaces, saturating; drop leading ones
            if (line_started_r && (pending_r < RUN_MAX)) begin
              pending_nxt = pending_r + SPACE_W'(1);
            end
          end else begin
            q_push           = 1'b1;
            pending_nxt      = '0;
            line_started_nxt = 1'b1;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_started_r <= 1'b0;
      pending_r      <= '0;
      term_run_r     <= 1'b0;
    end else begin
      line_started_r <= line_started_nxt;
      pending_r      <= pending_nxt;
      term_run_r     <= term_run_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tla_queue.sv
// Short command queue between the front and back ends.
`default_nettype none

module tla_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tla_pkg::tla_cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output tla_pkg::tla_cmd_t      head_cmd
);
  import tla_pkg::*;

  tla_cmd_t            mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QUEUE_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QUEUE_AW+1)'(1);
    end
  end

  // Write entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> full)
    else $error("full queue lost an entry");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/tla_back.sv
// Back end: expands commands into space, character and line-end items.
`default_nettype none

module tla_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire tla_pkg::tla_cmd_t q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_char_out,
  output logic                   out_line_end,
  output logic                   out_last
);
  import tla_pkg::*;

  tla_cmd_t           cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [SPACE_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic               out_end_r, out_end_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_free;
  logic               emit;
  logic               done;

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_line_end = out_end_r;
  assign out_last     = out_last_r;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = out_free && cur_valid_r;
  assign done     = emit && (cur_r.is_end || (cnt_r == '0));
  assign q_pop    = q_valid && (!cur_valid_r || done);

  // Step through the current command and load the next
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    cnt_nxt       = cnt_r;
    if (q_pop) begin
      cur_nxt       = q_cmd;
      cur_valid_nxt = 1'b1;
      cnt_nxt       = q_cmd.spaces;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      cnt_nxt = cnt_r - SPACE_W'(1);
    end
  end

  // Fill the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = emit;
      if (cur_r.is_end) begin
        out_char_nxt = 8'h00;
        out_end_nxt  = 1'b1;
        out_last_nxt = 1'b1;
      end else if (cnt_r != '0) begin
        out_char_nxt = CH_SPACE;
        out_end_nxt  = 1'b0;
        out_last_nxt = 1'b0;
      end else begin
        out_char_nxt = cur_r.ch;
        out_end_nxt  = 1'b0;
        out_last_nxt = 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_char_r   <= out_char_nxt;
    out_end_r    <= out_end_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (cur_valid_r && !cur_r.is_end))
    else $error("space count without a character command");
  a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_char_r == 8'h00 && out_last_r))
    else $error("malformed line-end item");
  a_inner_space: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_char_r == CH_SPACE && !out_end_r))
    else $error("non-final item is not a space");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/text_line_assembler.sv
// Top level of the text line assembler: front end, command queue, back end.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_byte_in[7:0]
//   out      output     out_valid/out_stall out_char_out[7:0], out_line_end, out_last
//
// A byte is taken in the cycle it is offered unless the command queue is full.
// The first item of a byte passes through a queue entry and the back end's current
// command register into the output register. A character preceded by N held spaces
// becomes N space items and the character, so the back end sets the rate then.
// Synchronous active-low reset clears line state, queue and output valid.
// Either side may stall independently; the queue absorbs the difference.
`default_nettype none

module text_line_assembler #(
  parameter int SPACE_RUN_MAX = 63
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char_out,
  output logic            out_line_end,
  output logic            out_last
);
  import tla_pkg::*;

  logic     q_full;
  logic     q_push;
  tla_cmd_t q_push_cmd;
  logic     q_pop;
  logic     q_valid;
  tla_cmd_t q_head;

  tla_front #(
    .SPACE_RUN_MAX(SPACE_RUN_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte_in (in_byte_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_push_cmd)
  );

  tla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  tla_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_line_end (out_line_end),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire
